// ----- design/stlr_pkg.sv -----
// shared constants and field codes for the tile layer pair renderer
`default_nettype none
package stlr_pkg;

    // storage sizes
    localparam int unsigned CHAR_BYTES = 524288;
    localparam int unsigned CHAR_AW    = $clog2(CHAR_BYTES);
    localparam int unsigned TILE_WORDS = 32768;

    // item kinds carried in tuser
    localparam logic [1:0] FUNC_TILE_WR = 2'd0;
    localparam logic [1:0] FUNC_CHAR_WR = 2'd1;
    localparam logic [1:0] FUNC_DRAW    = 2'd2;
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_LAYER_PAIR = 3'd0;
    localparam logic [2:0] CFG_CATEGORY   = 3'd1;
    localparam logic [2:0] CFG_OPAQUE     = 3'd2;
    localparam logic [2:0] CFG_WIDTH      = 3'd3;
    localparam logic [2:0] CFG_HEIGHT     = 3'd4;

    // scroll word block at 0x5000..0x5007, address bits 14:3
    localparam logic [11:0] SCROLL_BLOCK = 12'hA00;

    // base address prefixes
    localparam logic [2:0] MASK_PREFIX = 3'b110;   // 0x6000 / 0x6800
    localparam logic [3:0] LINE_PREFIX = 4'b1000;  // 0x4000

    // pair modes
    localparam logic [1:0] MODE_MASK   = 2'd0;
    localparam logic [1:0] MODE_VSPLIT = 2'd1;

endpackage
`default_nettype wire

// ----- design/stlr_ram.sv -----
// generic single write, single registered read memory
`default_nettype none
module stlr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/scrolling_tile_layer_pair_renderer.sv -----
// top level: five stage pixel pipeline over tile and character memories
//
// Input channel s_*: one word per item. tuser carries the kind: tile word
// write, character byte write or draw pixel. Writes give no result; each
// draw gives exactly one result word on m_*, in input order.
// Output tuser is the draw flag; when it is 0 tile_entry and pen are 0.
// A draw passes through the stage 1 to 4 registers and the output register before m_tvalid.
// Throughput is one item per clock unless a result waits on low m_tready:
// the tile memory is held in three copies (mask read, line scroll read,
// map entry read), each read by one stage, and the character memory is
// read by a fourth stage. Writes travel down the pipeline and update each
// copy at the stage that reads it, so every draw sees exactly the writes
// accepted before it. The eight scroll words are also kept in flip-flops.
// Configuration must be written on i_cfg_* while the block is idle; it is not enforced.
// A stalled receiver freezes the whole pipeline; s_tready falls only while
// a result waits and m_tready is low.
// Reset (synchronous, i_rst_n low) empties the pipeline and sets the
// registers to their defaults; memory contents are undefined until written.
`default_nettype none
module scrolling_tile_layer_pair_renderer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tile_addr[14:0] tile_data[30:15] char_addr[49:31] char_data[57:50]
    // pos_x[66:58] pos_y[75:67], zero pad to 80
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_x[8:0] out_y[17:9] tile_entry[33:18] pen[37:34], zero pad to 40
    output logic [39:0]      m_tdata,
    // draw[0]
    output logic             m_tuser
);
    import stlr_pkg::*;

    // configuration registers
    logic       r_layer_pair, r_opaque;
    logic [1:0] r_category;
    logic [9:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_pair <= 1'b0;
            r_category   <= 2'b11;
            r_opaque     <= 1'b0;
            r_width      <= 10'd496;
            r_height     <= 10'd384;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_LAYER_PAIR: r_layer_pair <= i_cfg_data[0];
                CFG_CATEGORY:   r_category   <= i_cfg_data[1:0];
                CFG_OPAQUE:     r_opaque     <= i_cfg_data[0];
                CFG_WIDTH:      r_width      <= i_cfg_data;
                CFG_HEIGHT:     r_height     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance
    logic w_adv;
    logic r_ov;
    assign w_adv    = !r_ov || m_tready;
    assign s_tready = w_adv;

    // input fields
    logic [1:0]  w_func;
    logic [14:0] w_taddr;
    logic [15:0] w_tdat;
    logic [18:0] w_caddr;
    logic [7:0]  w_cdat;
    logic [8:0]  w_x, w_y;
    assign w_func  = s_tuser;
    assign w_taddr = s_tdata[14:0];
    assign w_tdat  = s_tdata[30:15];
    assign w_caddr = s_tdata[49:31];
    assign w_cdat  = s_tdata[57:50];
    assign w_x     = s_tdata[66:58];
    assign w_y     = s_tdata[75:67];

    logic w_acc;
    assign w_acc = s_tvalid && w_adv;

    // scroll word shadow, updated at entry
    logic [15:0] r_scroll [8];
    always_ff @(posedge i_clk) begin
        if (w_acc && w_func == FUNC_TILE_WR && w_taddr[14:3] == SCROLL_BLOCK) begin
            r_scroll[w_taddr[2:0]] <= w_tdat;
        end
    end

    // ---------------- stage 1 registers
    logic        r_v1, r_d1;
    logic [1:0]  r_f1;
    logic [14:0] r_ta1;
    logic [15:0] r_td1;
    logic [18:0] r_ca1;
    logic [7:0]  r_cd1;
    logic [8:0]  r_x1, r_y1;
    logic [15:0] r_ph1, r_pv1, r_h1, r_v1w;
    logic [15:0] w_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_tvalid;
        end
    end

    // off screen check and scroll word capture
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1  <= w_func;
            r_ta1 <= w_taddr;
            r_td1 <= w_tdat;
            r_ca1 <= w_caddr;
            r_cd1 <= w_cdat;
            r_x1  <= w_x;
            r_y1  <= w_y;
            r_d1  <= ({1'b0, w_x} >= r_width) || ({1'b0, w_y} >= r_height);
            r_ph1 <= r_layer_pair ? r_scroll[2] : r_scroll[0];
            r_h1  <= r_layer_pair ? r_scroll[3] : r_scroll[1];
            r_pv1 <= r_layer_pair ? r_scroll[6] : r_scroll[4];
            r_v1w <= r_layer_pair ? r_scroll[7] : r_scroll[5];
        end
    end

    // mask read copy
    stlr_ram #(.WIDTH(16), .DEPTH(TILE_WORDS)) u_tile_a (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_acc && w_func == FUNC_TILE_WR),
        .i_waddr (w_taddr),
        .i_wdata (w_tdat),
        .i_raddr ({MASK_PREFIX, r_layer_pair, w_y, w_x[8:7]}),
        .o_rdata (w_mask)
    );

    // ---------------- stage 1 logic: page choice
    logic [1:0]  w_mode;
    logic        w_sel, w_split, w_lreq, w_d2;
    logic [1:0]  w_page, w_lpage;
    logic [15:0] w_hw, w_vw;
    logic [9:0]  w_neg;

    always_comb begin
        w_mode  = r_pv1[14:13];
        w_sel   = w_mask[~r_x1[6:3]];
        w_neg   = 10'(~r_pv1[9:0] + 10'd1);
        w_split = 1'b0;
        w_lpage = {r_layer_pair, 1'b0};
        w_hw    = r_ph1;
        w_vw    = r_pv1;
        w_lreq  = r_ph1[15];
        w_page  = {r_layer_pair, 1'b0};
        w_d2    = r_d1 || (w_mode != MODE_MASK && r_pv1[15]);
        case (w_mode)
            MODE_MASK: begin
                w_page  = {r_layer_pair, w_sel};
                w_lpage = w_page;
                w_hw    = w_sel ? r_h1 : r_ph1;
                w_vw    = w_sel ? r_v1w : r_pv1;
                w_lreq  = w_hw[15];
                w_d2    = r_d1 || w_vw[15];
            end
            MODE_VSPLIT: begin
                w_page = {r_layer_pair, !w_neg[9] ^ (r_y1 >= w_neg[8:0])};
            end
            default: begin
                w_split = 1'b1;
            end
        endcase
    end

    // ---------------- stage 2 registers
    logic        r_v2, r_d2, r_split2, r_lreq2;
    logic [1:0]  r_f2, r_page2;
    logic [14:0] r_ta2;
    logic [15:0] r_td2, r_hw2, r_vw2;
    logic [18:0] r_ca2;
    logic [7:0]  r_cd2;
    logic [8:0]  r_x2, r_y2;
    logic [15:0] w_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f2     <= r_f1;
            r_ta2    <= r_ta1;
            r_td2    <= r_td1;
            r_ca2    <= r_ca1;
            r_cd2    <= r_cd1;
            r_x2     <= r_x1;
            r_y2     <= r_y1;
            r_d2     <= w_d2;
            r_split2 <= w_split;
            r_lreq2  <= w_lreq;
            r_page2  <= w_page;
            r_hw2    <= w_hw;
            r_vw2    <= w_vw;
        end
    end

    // line scroll read copy
    stlr_ram #(.WIDTH(16), .DEPTH(TILE_WORDS)) u_tile_b (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_adv && r_v1 && r_f1 == FUNC_TILE_WR),
        .i_waddr (r_ta1),
        .i_wdata (r_td1),
        .i_raddr ({LINE_PREFIX, w_lpage, r_y1}),
        .o_rdata (w_line)
    );

    // ---------------- stage 2 logic: scroll and map address
    logic [15:0] w_hf;
    logic [1:0]  w_pg2;
    logic [8:0]  w_sx, w_sy;

    always_comb begin
        w_hf  = r_lreq2 ? w_line : r_hw2;
        w_pg2 = r_split2 ? {r_page2[1], !w_hf[9] ^ (r_x2 >= w_hf[8:0])} : r_page2;
        w_sx  = 9'(~w_hf[8:0] + 9'd1 + r_x2);
        w_sy  = 9'(r_vw2[8:0] + r_y2);
    end

    // ---------------- stage 3 registers
    logic        r_v3, r_d3;
    logic [1:0]  r_f3;
    logic [18:0] r_ca3;
    logic [7:0]  r_cd3;
    logic [8:0]  r_x3, r_y3;
    logic [2:0]  r_sx3, r_sy3;
    logic [15:0] w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f3  <= r_f2;
            r_ca3 <= r_ca2;
            r_cd3 <= r_cd2;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            r_d3  <= r_d2;
            r_sx3 <= w_sx[2:0];
            r_sy3 <= w_sy[2:0];
        end
    end

    // map entry read copy
    stlr_ram #(.WIDTH(16), .DEPTH(TILE_WORDS)) u_tile_c (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_adv && r_v2 && r_f2 == FUNC_TILE_WR),
        .i_waddr (r_ta2),
        .i_wdata (r_td2),
        .i_raddr ({1'b0, w_pg2, w_sy[8:3], w_sx[8:3]}),
        .o_rdata (w_entry)
    );

    // ---------------- stage 3 logic: category and pattern address
    logic [18:0] w_cra;
    logic [19:0] w_last;
    logic        w_d4, w_cwr;

    always_comb begin
        w_cra  = {w_entry[13:0], r_sy3, r_sx3[2], !r_sx3[1]};
        w_last = {1'b0, w_entry[13:0], r_sy3, 2'b11};
        w_d4   = r_d3 || (!r_category[1] && (w_entry[15] != r_category[0]))
                 || (w_last >= 20'(CHAR_BYTES));
        w_cwr  = {1'b0, r_ca3} < 20'(CHAR_BYTES);
    end

    // ---------------- stage 4 registers
    logic        r_v4, r_d4, r_odd4;
    logic [1:0]  r_f4;
    logic [8:0]  r_x4, r_y4;
    logic [15:0] r_e4;
    logic [7:0]  w_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f4   <= r_f3;
            r_x4   <= r_x3;
            r_y4   <= r_y3;
            r_d4   <= w_d4;
            r_e4   <= w_entry;
            r_odd4 <= r_sx3[0];
        end
    end

    // character pattern memory
    stlr_ram #(.WIDTH(8), .DEPTH(CHAR_BYTES)) u_char (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_we    (w_adv && r_v3 && r_f3 == FUNC_CHAR_WR && w_cwr),
        .i_waddr (r_ca3[CHAR_AW-1:0]),
        .i_wdata (r_cd3),
        .i_raddr (w_cra[CHAR_AW-1:0]),
        .o_rdata (w_pat)
    );

    // ---------------- stage 4 logic: pen and output word
    logic [3:0] w_pen;
    logic       w_draw;
    assign w_pen  = r_odd4 ? w_pat[3:0] : w_pat[7:4];
    assign w_draw = !r_d4 && (r_opaque || w_pen != 4'd0);

    logic [39:0] r_odata;
    logic        r_odraw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_v4 && r_f4 == FUNC_DRAW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_odraw <= w_draw;
            r_odata <= {2'b00, w_draw ? w_pen : 4'd0, w_draw ? r_e4 : 16'd0, r_y4, r_x4};
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_odraw;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// testbench for the tile layer pair renderer: directed rows, then random words
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import stlr_pkg::*;

    localparam int HSCROLL = 'h5000;
    localparam int VSCROLL = 'h5004;
    localparam int LINE_BASE = 'h4000;
    localparam int LINE_STRIDE = 'h200;
    localparam int MASK_PAIR0 = 'h6000;
    localparam int MASK_PAIR1 = 'h6800;
    localparam int PAGE_SIZE = 'h1000;
    localparam int STALL_LIMIT = 3000;
    localparam int WORDS_PER_PHASE = 85;
    localparam int LONG_HOLD = 250;

    // how a directed row is checked
    typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_NODRAW} t_row_kind;

    typedef struct packed {
        logic [1:0]  fn;
        logic [14:0] addr;
        logic [15:0] data;
        logic [8:0]  px;
        logic [8:0]  py;
        t_row_kind   kind;
    } t_row;

    typedef struct packed {
        logic [8:0]  x;
        logic [8:0]  y;
        logic        draw;
        logic [15:0] entry;
        logic [3:0]  pen;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_idx;
    logic [9:0]  i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    scrolling_tile_layer_pair_renderer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow of the block's memories and registers
    logic [15:0]        tile_mem [TILE_WORDS];
    bit                 tile_seen [TILE_WORDS];
    logic [7:0]         char_mem [CHAR_BYTES];
    bit                 char_seen [CHAR_BYTES];
    logic               pair_sel;
    logic signed [1:0]  category;
    logic               opaque;
    int                 scr_w;
    int                 scr_h;
    int                 miss_tile;
    int                 miss_char;

    t_pixel pending_pixels [$];
    int     errors;
    int     hold_left;
    int     hold_asks;
    int     hold_seen;
    int     ready_pct;
    bit     gaps_on;
    int     idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // tile read that notes the first word never written
    function automatic logic [15:0] tile_rd(input int a);
        a = a & (TILE_WORDS - 1);
        if (!tile_seen[a] && miss_tile < 0) miss_tile = a;
        return tile_mem[a];
    endfunction

    // pixel shading as the block computes it
    function automatic t_pixel shade_pixel(input int x, input int y);
        t_pixel r;
        int bp, pg, ph, pv, hw, vw, md, mk, ng, sx, sy, ent, row, pix, pk, pn;
        r = '0;
        r.x = 9'(x);
        r.y = 9'(y);
        if (x >= scr_w || y >= scr_h) return r;
        bp = pair_sel * 2;
        ph = tile_rd(HSCROLL + bp);
        pv = tile_rd(VSCROLL + bp);
        md = (pv >> 13) & 3;
        if (md != 0 && pv[15]) return r;
        pg = bp;
        hw = ph;
        vw = pv;
        if (md == 0) begin
            mk = tile_rd((pair_sel ? MASK_PAIR1 : MASK_PAIR0) + y * 4 + (x >> 7));
            if (mk[15 - ((x & 127) >> 3)]) pg++;
            hw = tile_rd(HSCROLL + pg);
            vw = tile_rd(VSCROLL + pg);
            if (vw[15]) return r;
            if (hw[15]) hw = tile_rd(LINE_BASE + LINE_STRIDE * pg + y);
        end else if (md == 1) begin
            ng = -pv;
            if (!ng[9]) pg ^= 1;
            if (y >= (ng & 'h1ff)) pg ^= 1;
            if (ph[15]) hw = tile_rd(LINE_BASE + LINE_STRIDE * bp + y);
        end else begin
            if (ph[15]) hw = tile_rd(LINE_BASE + LINE_STRIDE * bp + y);
            if (!hw[9]) pg ^= 1;
            if (x >= (hw & 'h1ff)) pg ^= 1;
        end
        sx = ((-hw) + x) & 'h1ff;
        sy = ((vw & 'h1ff) + y) & 'h1ff;
        ent = tile_rd(pg * PAGE_SIZE + (sy >> 3) * 64 + (sx >> 3));
        if (category >= 0 && ent[15] != category[0]) return r;
        row = (ent & 'h3fff) * 32 + (sy & 7) * 4;
        if (row + 3 >= CHAR_BYTES) return r;
        pix = sx & 7;
        pk = row + ((pix >> 1) ^ 1);
        if (!char_seen[pk] && miss_char < 0) miss_char = pk;
        pk = char_mem[pk];
        pn = (pix & 1) ? (pk & 'hf) : (pk >> 4);
        if (!opaque && pn == 0) return r;
        r.draw = 1'b1;
        r.entry = 16'(ent);
        r.pen = 4'(pn);
        return r;
    endfunction

    // offer one word and wait for it to be taken
    task automatic send_word(input logic [1:0] fn, input logic [14:0] ta,
                             input logic [15:0] td, input logic [18:0] ca,
                             input logic [7:0] cd, input logic [8:0] px,
                             input logic [8:0] py, input bit has_pix, input t_pixel pix);
        int gap;
        @(negedge i_clk);
        gap = 0;
        if (gaps_on && $urandom_range(0, 9) >= 6)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata = {4'b0, py, px, cd, ca, td, ta};
        s_tuser = fn;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        if (has_pix) pending_pixels.push_back(pix);
    endtask

    task automatic tile_write(input int a, input logic [15:0] d);
        tile_mem[a] = d;
        tile_seen[a] = 1'b1;
        send_word(FUNC_TILE_WR, 15'(a), d, 19'($urandom), 8'($urandom), 9'($urandom),
                  9'($urandom), 1'b0, '0);
    endtask

    task automatic char_write(input int a, input logic [7:0] d);
        char_mem[a] = d;
        char_seen[a] = 1'b1;
        send_word(FUNC_CHAR_WR, 15'($urandom), 16'($urandom), 19'(a), d, 9'($urandom),
                  9'($urandom), 1'b0, '0);
    endtask

    // fill every word the pixel will read, then send it
    task automatic draw_pixel(input int x, input int y, input bit force_blank);
        t_pixel p;
        logic [15:0] d;
        forever begin
            miss_tile = -1;
            miss_char = -1;
            p = shade_pixel(x, y);
            if (miss_tile >= 0) begin
                d = 16'($urandom);
                if (miss_tile >= HSCROLL && miss_tile < HSCROLL + 8 && $urandom_range(0, 3) != 0)
                    d[15] = 1'b0;
                tile_write(miss_tile, d);
            end else if (miss_char >= 0) begin
                char_write(miss_char, 8'($urandom));
            end else begin
                break;
            end
        end
        if (force_blank) p = '{x: 9'(x), y: 9'(y), draw: 1'b0, entry: 16'd0, pen: 4'd0};
        send_word(FUNC_DRAW, 15'($urandom), 16'($urandom), 19'($urandom), 8'($urandom),
                  9'(x), 9'(y), 1'b1, p);
    endtask

    // register write once the pipeline has drained
    task automatic cfg_write(input logic [2:0] idx, input logic [9:0] val);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wen = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_wen = 1'b0;
        case (idx)
            CFG_LAYER_PAIR: pair_sel = val[0];
            CFG_CATEGORY:   category = val[1:0];
            CFG_OPAQUE:     opaque = val[0];
            CFG_WIDTH:      scr_w = val;
            CFG_HEIGHT:     scr_h = val;
            default: ;
        endcase
    endtask

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            m_tready <= 1'b0;
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            m_tready <= 1'b0;
            hold_left <= $urandom_range(10, 40);
        end else begin
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d", $time, m_tdata[8:0], m_tdata[17:9]);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[8:0] !== want.x || m_tdata[17:9] !== want.y
                        || m_tuser !== want.draw || m_tdata[33:18] !== want.entry
                        || m_tdata[37:34] !== want.pen || m_tdata[39:38] !== 2'b0) begin
                    $display("%0t: mismatch expected x=%0d y=%0d draw=%0d entry=%h pen=%h",
                             $time, want.x, want.y, want.draw, want.entry, want.pen);
                    $display("%0t:          actual x=%0d y=%0d draw=%0d entry=%h pen=%h",
                             $time, m_tdata[8:0], m_tdata[17:9], m_tuser,
                             m_tdata[33:18], m_tdata[37:34]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_wen || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows [20];
        int lp [8], cat [8], opq [8], wid [8], hgt [8];
        int ph, n, sel, x, y, a;
        logic [15:0] d;

        // directed rows: reset extremes, pair and page disables, function codes
        rows[0]  = '{FUNC_DRAW, 0, 0, 496, 0, ROW_NODRAW};
        rows[1]  = '{FUNC_DRAW, 0, 0, 0, 384, ROW_NODRAW};
        rows[2]  = '{FUNC_DRAW, 0, 0, 511, 511, ROW_NODRAW};
        rows[3]  = '{FUNC_TILE_WR, 15'(HSCROLL), 16'h0000, 0, 0, ROW_WRITE};
        rows[4]  = '{FUNC_TILE_WR, 15'(VSCROLL), 16'hA000, 0, 0, ROW_WRITE};
        rows[5]  = '{FUNC_DRAW, 0, 0, 0, 0, ROW_NODRAW};
        rows[6]  = '{FUNC_TILE_WR, 15'(VSCROLL), 16'h2000, 0, 0, ROW_WRITE};
        rows[7]  = '{FUNC_DRAW, 0, 0, 0, 0, ROW_PREDICT};
        rows[8]  = '{FUNC_DRAW, 0, 0, 495, 383, ROW_PREDICT};
        rows[9]  = '{FUNC_TILE_WR, 15'(VSCROLL), 16'h4000, 0, 0, ROW_WRITE};
        rows[10] = '{FUNC_DRAW, 0, 0, 100, 50, ROW_PREDICT};
        rows[11] = '{FUNC_TILE_WR, 15'(VSCROLL), 16'h0000, 0, 0, ROW_WRITE};
        rows[12] = '{FUNC_TILE_WR, 15'(VSCROLL + 1), 16'h8000, 0, 0, ROW_WRITE};
        rows[13] = '{FUNC_TILE_WR, 15'(HSCROLL + 1), 16'h8000, 0, 0, ROW_WRITE};
        rows[14] = '{FUNC_TILE_WR, 15'(MASK_PAIR0), 16'hFFFF, 0, 0, ROW_WRITE};
        rows[15] = '{FUNC_DRAW, 0, 0, 3, 0, ROW_NODRAW};
        rows[16] = '{FUNC_TILE_WR, 'h7FFF, 16'hFFFF, 0, 0, ROW_WRITE};
        rows[17] = '{FUNC_CHAR_WR, 'h7FFF, 16'h00FF, 0, 0, ROW_WRITE};
        rows[18] = '{FUNC_DRAW, 0, 0, 200, 10, ROW_PREDICT};
        rows[19] = '{FUNC_IGNORED, 'h7FFF, 16'hFFFF, 511, 511, ROW_WRITE};

        // register settings per phase, extremes included
        lp  = '{0, 1, 0, 1, 0, 1, 0, 1};
        cat = '{-1, 0, 1, -2, 0, 1, -1, -1};
        opq = '{0, 1, 0, 1, 0, 1, 1, 0};
        wid = '{496, 512, 1, 300, 512, 1, 512, 200};
        hgt = '{384, 512, 1, 200, 1, 512, 512, 100};

        ready_pct = 100;
        gaps_on = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        pair_sel = 1'b0;
        category = -2'sd1;
        opaque = 1'b0;
        scr_w = 496;
        scr_h = 384;
        repeat (2) @(posedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_NODRAW:  draw_pixel(rows[i].px, rows[i].py, 1'b1);
                ROW_PREDICT: draw_pixel(rows[i].px, rows[i].py, 1'b0);
                default: begin
                    if (rows[i].fn == FUNC_TILE_WR)
                        tile_write(rows[i].addr, rows[i].data);
                    else if (rows[i].fn == FUNC_CHAR_WR)
                        char_write({4'hF, rows[i].addr}, rows[i].data[7:0]);
                    else
                        send_word(rows[i].fn, rows[i].addr, rows[i].data, '1, '1,
                                  rows[i].px, rows[i].py, 1'b0, '0);
                end
            endcase
        end

        for (ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_LAYER_PAIR, 10'(lp[ph]));
            cfg_write(CFG_CATEGORY, 10'(cat[ph] & 3));
            cfg_write(CFG_OPAQUE, 10'(opq[ph]));
            cfg_write(CFG_WIDTH, 10'(wid[ph]));
            cfg_write(CFG_HEIGHT, 10'(hgt[ph]));
            // the first phase runs with no input gaps and ready_pct at 100; random receiver hold-offs still apply
            gaps_on = (ph != 0);
            ready_pct = (ph == 0) ? 100 : $urandom_range(50, 95);
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 2 && n == 40) hold_asks++;
                if (ph == 3 && n == 50) begin
                    @(negedge i_clk);
                    s_tvalid = 1'b0;
                    while (pending_pixels.size() != 0) @(posedge i_clk);
                end
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    // mostly on screen, some beyond
                    x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                   : $urandom_range(0, scr_w - 1);
                    y = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                   : $urandom_range(0, scr_h - 1);
                    draw_pixel(x, y, 1'b0);
                end else if (sel < 78) begin
                    // scroll and mode words
                    a = HSCROLL + $urandom_range(0, 7);
                    d = 16'($urandom);
                    if ($urandom_range(0, 3) != 0) d[15] = 1'b0;
                    tile_write(a, d);
                end else if (sel < 88) begin
                    tile_write($urandom_range(0, TILE_WORDS - 1), 16'($urandom));
                end else if (sel < 96) begin
                    char_write($urandom_range(0, CHAR_BYTES - 1), 8'($urandom));
                end else begin
                    send_word(FUNC_IGNORED, 15'($urandom), 16'($urandom), 19'($urandom),
                              8'($urandom), 9'($urandom), 9'($urandom), 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
